### design/fmsx_pkg.sv
// ----------------------------------------------------------------------------
// fmsx_pkg
// Shared types, constants and the bulk-voice bit-field unpack table for the
// voice dump system-exclusive unpacker.
// ----------------------------------------------------------------------------
package fmsx_pkg;

  // Message framing and header constants
  localparam logic [7:0]  SOX_BYTE      = 8'hF0;
  localparam logic [7:0]  EOX_BYTE      = 8'hF7;
  localparam logic [7:0]  MAKER_ID      = 8'h43;
  localparam logic [7:0]  FMT_SINGLE    = 8'h00;
  localparam logic [7:0]  FMT_BULK      = 8'h09;
  localparam logic [13:0] LEN_SINGLE    = 14'd155;
  localparam logic [13:0] LEN_BULK      = 14'd4096;
  localparam logic [14:0] HDR_LEN       = 15'd6;
  localparam logic [14:0] POS_MAX       = 15'd32767;
  localparam logic [7:0]  FILL_PARAM    = 8'd155;
  localparam logic [7:0]  FILL_VALUE    = 8'h3F;
  localparam logic [7:0]  LAST_SINGLE_D = 8'd154;
  localparam int unsigned MAX_RESULTS   = 4;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FRAMING  = 3'd1;
  localparam logic [2:0] ST_MAKER    = 3'd2;
  localparam logic [2:0] ST_COUNT    = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;
  localparam logic [2:0] ST_FORMAT   = 3'd5;

  // Result kinds
  localparam logic KIND_PARAM  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] voice;
    logic [7:0] param;
    logic [7:0] value;
    logic [2:0] status;
    logic       last_of_run;
  } out_item_t;

  // Up to three parameters from one packed bulk byte
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] param;
    logic [2:0][7:0] value;
  } bulk_t;

  // Unpack one byte at offset o of a 128-byte packed voice.
  function automatic bulk_t unpack_bulk(input logic [6:0] o, input logic [7:0] b);
    bulk_t      r;
    logic [2:0] q;
    logic [6:0] j;
    logic [7:0] base;
    r    = '0;
    q    = 3'd0;
    if (o >= 7'd85)      q = 3'd5;
    else if (o >= 7'd68) q = 3'd4;
    else if (o >= 7'd51) q = 3'd3;
    else if (o >= 7'd34) q = 3'd2;
    else if (o >= 7'd17) q = 3'd1;
    j    = o - ({4'b0, q} * 7'd17);
    base = {5'b0, q} * 8'd21;
    if (o < 7'd102) begin
      if (j < 7'd11) begin
        r.cnt = 2'd1; r.param[0] = base + {1'b0, j}; r.value[0] = b;
      end else begin
        case (j)
          7'd11: begin
            r.cnt = 2'd2;
            r.param[0] = base + 8'd11; r.value[0] = {6'b0, b[1:0]};
            r.param[1] = base + 8'd12; r.value[1] = {6'b0, b[3:2]};
          end
          7'd12: begin
            r.cnt = 2'd2;
            r.param[0] = base + 8'd13; r.value[0] = {5'b0, b[2:0]};
            r.param[1] = base + 8'd20; r.value[1] = {4'b0, b[6:3]};
          end
          7'd13: begin
            r.cnt = 2'd2;
            r.param[0] = base + 8'd14; r.value[0] = {6'b0, b[1:0]};
            r.param[1] = base + 8'd15; r.value[1] = {5'b0, b[4:2]};
          end
          7'd14: begin
            r.cnt = 2'd1; r.param[0] = base + 8'd16; r.value[0] = b;
          end
          7'd15: begin
            r.cnt = 2'd2;
            r.param[0] = base + 8'd17; r.value[0] = {7'b0, b[0]};
            r.param[1] = base + 8'd18; r.value[1] = {3'b0, b[5:1]};
          end
          default: begin
            r.cnt = 2'd1; r.param[0] = base + 8'd19; r.value[0] = b;
          end
        endcase
      end
    end else if (o < 7'd110) begin
      r.cnt = 2'd1; r.param[0] = {1'b0, o} + 8'd24; r.value[0] = b;
    end else if (o == 7'd110) begin
      r.cnt = 2'd1; r.param[0] = 8'd134; r.value[0] = {3'b0, b[4:0]};
    end else if (o == 7'd111) begin
      r.cnt = 2'd2;
      r.param[0] = 8'd135; r.value[0] = {5'b0, b[2:0]};
      r.param[1] = 8'd136; r.value[1] = {7'b0, b[3]};
    end else if (o < 7'd116) begin
      r.cnt = 2'd1; r.param[0] = {1'b0, o} + 8'd25; r.value[0] = b;
    end else if (o == 7'd116) begin
      r.cnt = 2'd3;
      r.param[0] = 8'd141; r.value[0] = {7'b0, b[0]};
      r.param[1] = 8'd142; r.value[1] = {5'b0, b[3:1]};
      r.param[2] = 8'd143; r.value[2] = {5'b0, b[6:4]};
    end else if (o == 7'd117) begin
      r.cnt = 2'd1; r.param[0] = 8'd144; r.value[0] = b;
    end else begin
      r.cnt = 2'd1; r.param[0] = {1'b0, o} + 8'd27; r.value[0] = b;
      if (o == 7'd127) begin
        r.cnt = 2'd2; r.param[1] = FILL_PARAM; r.value[1] = FILL_VALUE;
      end
    end
    return r;
  endfunction

endpackage

### design/fm_voice_sysex_unpacker.sv
// ----------------------------------------------------------------------------
// fm_voice_sysex_unpacker
// Checks and unpacks a system-exclusive voice dump (single voice or 32-voice
// bulk), emitting parameters cut-through and one status per message.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | to block  | in_valid / in_ready   | in_item  (in_byte, is_final)
//  out     | from block| out_valid / out_ready | out_item (kind .. last_of_run)
//
//  Each accepted byte is decoded in the cycle of its transfer and its 0..4
//  results land in a small result buffer; they leave one per cycle while out_ready
//  is high, the first one valid the cycle after the input transfer.
//  A byte therefore holds the input until its last result leaves: most bytes
//  give at most one result, a bulk byte that holds three fields plus status gives 4.
//  in_ready is high when the buffer is empty or its last result leaves now.
//  Reset (rst, synchronous) clears the message state and empties the buffer.
//  Output stalls hold the buffer; the input is back-pressured meanwhile.
//
module fm_voice_sysex_unpacker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fmsx_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fmsx_pkg::out_item_t  out_item
);

  // Message state
  logic [14:0] byte_position;
  logic        header_good;
  logic        maker_good;
  logic [7:0]  format_code;
  logic [13:0] data_length;
  logic [6:0]  running_sum;
  logic [7:0]  received_check;
  logic        emit_enabled;

  logic        header_good_next;
  logic        maker_good_next;
  logic [7:0]  format_code_next;
  logic [13:0] data_length_next;
  logic [6:0]  running_sum_next;
  logic [7:0]  received_check_next;
  logic        emit_enabled_next;
  logic [14:0] byte_position_inc;

  // Result buffer
  fmsx_pkg::out_item_t rbuf [fmsx_pkg::MAX_RESULTS];
  logic [1:0]          rptr;
  logic [2:0]          rcnt;

  fmsx_pkg::out_item_t res [fmsx_pkg::MAX_RESULTS];
  logic [2:0]          nres;

  logic        in_xfer;
  logic        out_xfer;
  logic [7:0]  b;
  logic        fin;
  logic [14:0] dend;
  logic [14:0] d;
  logic        in_data;
  logic        at_check;
  logic [1:0]  pn;
  logic [2:0][7:0] p_param;
  logic [2:0][7:0] p_value;
  logic [4:0]  p_voice;
  fmsx_pkg::bulk_t bulk;
  logic [2:0]  st;
  logic [15:0] total;
  logic [6:0]  sum_neg;
  logic        fmt_ok;

  assign b        = in_item.in_byte;
  assign fin      = in_item.is_final;
  assign out_valid = (rcnt != 3'd0);
  assign out_item  = rbuf[rptr];
  assign out_xfer  = out_valid && out_ready;
  assign in_ready  = (rcnt == 3'd0) || ((rcnt == 3'd1) && out_ready);
  assign in_xfer   = in_valid && in_ready;

  // Data window uses the size as it stood before this byte
  assign dend     = fmsx_pkg::HDR_LEN + {1'b0, data_length};
  assign d        = byte_position - fmsx_pkg::HDR_LEN;
  assign in_data  = (byte_position >= fmsx_pkg::HDR_LEN) && (byte_position < dend);
  assign at_check = (byte_position >= fmsx_pkg::HDR_LEN) && (byte_position == dend);

  // Header capture
  always_comb begin
    header_good_next    = header_good;
    maker_good_next     = maker_good;
    format_code_next    = format_code;
    data_length_next    = data_length;
    emit_enabled_next   = emit_enabled;
    if (byte_position == 15'd0) header_good_next = (b == fmsx_pkg::SOX_BYTE);
    if (byte_position == 15'd1) maker_good_next  = (b == fmsx_pkg::MAKER_ID);
    if (byte_position == 15'd3) format_code_next = b;
    if (byte_position == 15'd4) data_length_next = {b[6:0], 7'd0};
    if (byte_position == 15'd5) begin
      data_length_next  = {data_length[13:7], b[6:0]};
      emit_enabled_next = header_good && maker_good &&
        (((format_code == fmsx_pkg::FMT_SINGLE) &&
          ({data_length[13:7], b[6:0]} == fmsx_pkg::LEN_SINGLE)) ||
         ((format_code == fmsx_pkg::FMT_BULK) &&
          ({data_length[13:7], b[6:0]} == fmsx_pkg::LEN_BULK)));
    end
    running_sum_next    = in_data ? (running_sum + b[6:0]) : running_sum;
    received_check_next = at_check ? b : received_check;
    byte_position_inc   = (byte_position < fmsx_pkg::POS_MAX) ?
                          (byte_position + 15'd1) : byte_position;
  end

  // Parameter extraction for this byte
  assign bulk = fmsx_pkg::unpack_bulk(d[6:0], b);

  always_comb begin
    pn      = 2'd0;
    p_param = '0;
    p_value = '0;
    p_voice = 5'd0;
    if (in_data && emit_enabled) begin
      if (format_code == fmsx_pkg::FMT_SINGLE) begin
        pn         = 2'd1;
        p_param[0] = d[7:0];
        p_value[0] = b;
        if (d[7:0] == fmsx_pkg::LAST_SINGLE_D) begin
          pn         = 2'd2;
          p_param[1] = fmsx_pkg::FILL_PARAM;
          p_value[1] = fmsx_pkg::FILL_VALUE;
        end
      end else begin
        pn      = bulk.cnt;
        p_param = bulk.param;
        p_value = bulk.value;
        p_voice = d[11:7];
      end
    end
  end

  // Message status, checks in priority order on the updated state
  assign total   = {1'b0, byte_position} + 16'd1;
  assign sum_neg = 7'd0 - running_sum_next;
  assign fmt_ok  =
    ((format_code_next == fmsx_pkg::FMT_SINGLE) && (data_length_next == fmsx_pkg::LEN_SINGLE)) ||
    ((format_code_next == fmsx_pkg::FMT_BULK) && (data_length_next == fmsx_pkg::LEN_BULK));

  always_comb begin
    if (total < 16'd8 || !header_good_next || b != fmsx_pkg::EOX_BYTE)
      st = fmsx_pkg::ST_FRAMING;
    else if (!maker_good_next)
      st = fmsx_pkg::ST_MAKER;
    else if (total != ({2'b0, data_length_next} + 16'd8))
      st = fmsx_pkg::ST_COUNT;
    else if ({1'b0, sum_neg} != received_check_next)
      st = fmsx_pkg::ST_CHECKSUM;
    else if (!fmt_ok)
      st = fmsx_pkg::ST_FORMAT;
    else
      st = fmsx_pkg::ST_OK;
  end

  // Assemble this byte's results: parameters, then status on the final byte
  always_comb begin
    for (int k = 0; k < fmsx_pkg::MAX_RESULTS; k++) res[k] = '0;
    for (int k = 0; k < 3; k++) begin
      if (k < int'(pn)) begin
        res[k].kind  = fmsx_pkg::KIND_PARAM;
        res[k].voice = p_voice;
        res[k].param = p_param[k];
        res[k].value = p_value[k];
      end
    end
    if (fin) begin
      res[pn].kind   = fmsx_pkg::KIND_STATUS;
      res[pn].status = st;
    end
    nres = {1'b0, pn} + {2'b0, fin};
    if (nres != 3'd0) res[2'(nres - 3'd1)].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      header_good    <= 1'b0;
      maker_good     <= 1'b0;
      format_code    <= '0;
      data_length    <= '0;
      running_sum    <= '0;
      received_check <= '0;
      emit_enabled   <= 1'b0;
      rptr           <= '0;
      rcnt           <= '0;
    end else begin
      // a new run only loads when the buffer is empty or its last result leaves
      if (in_xfer && nres != 3'd0) begin
        rptr <= '0;
        rcnt <= nres;
      end else if (out_xfer) begin
        rptr <= rptr + 2'd1;
        rcnt <= rcnt - 3'd1;
      end
      if (in_xfer) begin
        if (fin) begin
          byte_position  <= '0;
          header_good    <= 1'b0;
          maker_good     <= 1'b0;
          format_code    <= '0;
          data_length    <= '0;
          running_sum    <= '0;
          received_check <= '0;
          emit_enabled   <= 1'b0;
        end else begin
          byte_position  <= byte_position_inc;
          header_good    <= header_good_next;
          maker_good     <= maker_good_next;
          format_code    <= format_code_next;
          data_length    <= data_length_next;
          running_sum    <= running_sum_next;
          received_check <= received_check_next;
          emit_enabled   <= emit_enabled_next;
        end
      end
    end
  end

  // Result payload buffer, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer && nres != 3'd0) begin
      for (int k = 0; k < fmsx_pkg::MAX_RESULTS; k++) rbuf[k] <= res[k];
    end
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    rcnt <= 3'(fmsx_pkg::MAX_RESULTS))
    else $error("result count out of range");

  a_last_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last_of_run) |-> (rcnt == 3'd1))
    else $error("last_of_run not on the final buffered result");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.kind == fmsx_pkg::KIND_STATUS) |-> out_item.last_of_run)
    else $error("status result not closing its run");

  a_param_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.kind == fmsx_pkg::KIND_PARAM) |-> (out_item.param <= 8'd155))
    else $error("parameter index out of range");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_item.is_final) |=> (byte_position == 15'd0))
    else $error("message state not cleared after final byte");

endmodule

### sim/fm_voice_sysex_unpacker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_voice_sysex_unpacker_test
// Streams system-exclusive messages (a bulk dump cut off in its second voice,
// bad headers, short messages, noise) into the unpacker under random
// back-pressure. Every result transfer is compared field by field against an
// in-bench decoder of the same dump format.
// ----------------------------------------------------------------------------
module fm_voice_sysex_unpacker_test;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  fmsx_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  fmsx_pkg::out_item_t out_item;

  fm_voice_sysex_unpacker u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #4 clk = ~clk;

  // Bytes waiting to be sent, and the results the decoder below says are due.
  fmsx_pkg::in_item_t  byte_feed[$];
  fmsx_pkg::out_item_t predicted_results[$];
  fmsx_pkg::out_item_t byte_results[$];

  // Idle rates in percent for the sending and the receiving side.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          fail_count    = 0;

  // --------------------------------------------------------------------------
  // Decoder state for the message in flight
  // --------------------------------------------------------------------------
  logic [14:0] msg_pos;
  logic        sox_seen;
  logic        maker_seen;
  logic [7:0]  msg_format;
  logic [13:0] msg_len;
  logic [6:0]  data_sum;
  logic [7:0]  check_byte;
  logic        params_on;

  function automatic void clear_message();
    msg_pos    = '0;
    sox_seen   = 1'b0;
    maker_seen = 1'b0;
    msg_format = '0;
    msg_len    = '0;
    data_sum   = '0;
    check_byte = '0;
    params_on  = 1'b0;
  endfunction

  function automatic logic dump_supported(logic [7:0] f, logic [13:0] len);
    return (f == fmsx_pkg::FMT_SINGLE && len == fmsx_pkg::LEN_SINGLE) ||
           (f == fmsx_pkg::FMT_BULK && len == fmsx_pkg::LEN_BULK);
  endfunction

  function automatic void keep_result(fmsx_pkg::out_item_t r);
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void push_param(logic [4:0] v, int unsigned p, logic [7:0] val);
    fmsx_pkg::out_item_t r;
    r.kind        = fmsx_pkg::KIND_PARAM;
    r.voice       = v;
    r.param       = 8'(p);
    r.value       = val;
    r.status      = fmsx_pkg::ST_OK;
    r.last_of_run = 1'b0;
    keep_result(r);
  endfunction

  // One byte of a 128-byte packed voice: six operators of 17 bytes each, then
  // the voice-wide fields. Several bytes carry two or three bit fields.
  function automatic void split_packed_byte(logic [4:0] v, int unsigned o, logic [7:0] b);
    int unsigned base;
    int unsigned j;
    base = (o / 17) * 21;
    j    = o % 17;
    if (o < 102) begin
      if (j < 11) begin
        push_param(v, base + j, b);
      end else begin
        case (j)
          11: begin
            push_param(v, base + 11, b & 8'h03);
            push_param(v, base + 12, (b >> 2) & 8'h03);
          end
          12: begin
            push_param(v, base + 13, b & 8'h07);
            push_param(v, base + 20, (b >> 3) & 8'h0F);
          end
          13: begin
            push_param(v, base + 14, b & 8'h03);
            push_param(v, base + 15, (b >> 2) & 8'h07);
          end
          14: push_param(v, base + 16, b);
          15: begin
            push_param(v, base + 17, b & 8'h01);
            push_param(v, base + 18, (b >> 1) & 8'h1F);
          end
          default: push_param(v, base + 19, b);
        endcase
      end
    end else if (o < 110) begin
      push_param(v, 126 + o - 102, b);
    end else if (o == 110) begin
      push_param(v, 134, b & 8'h1F);
    end else if (o == 111) begin
      push_param(v, 135, b & 8'h07);
      push_param(v, 136, (b >> 3) & 8'h01);
    end else if (o < 116) begin
      push_param(v, 137 + o - 112, b);
    end else if (o == 116) begin
      push_param(v, 141, b & 8'h01);
      push_param(v, 142, (b >> 1) & 8'h07);
      push_param(v, 143, (b >> 4) & 8'h07);
    end else if (o == 117) begin
      push_param(v, 144, b);
    end else begin
      push_param(v, 145 + ((o - 118) & 15), b);
      if (o == 127) push_param(v, fmsx_pkg::FILL_PARAM, fmsx_pkg::FILL_VALUE);
    end
  endfunction

  // Works out every result that one accepted byte causes and queues them.
  function automatic void predict_byte(logic [7:0] b, logic fin);
    int unsigned         pos;
    int unsigned         data_end;
    int unsigned         d;
    int unsigned         total;
    logic [6:0]          want_check;
    fmsx_pkg::out_item_t st;
    pos      = msg_pos;
    data_end = int'(fmsx_pkg::HDR_LEN) + msg_len;
    byte_results.delete();

    // header capture
    if (pos == 0) sox_seen = (b == fmsx_pkg::SOX_BYTE);
    if (pos == 1) maker_seen = (b == fmsx_pkg::MAKER_ID);
    if (pos == 3) msg_format = b;
    if (pos == 4) msg_len = {b[6:0], 7'd0};
    if (pos == 5) begin
      msg_len[6:0] = b[6:0];
      params_on    = sox_seen && maker_seen && dump_supported(msg_format, msg_len);
    end

    // data bytes feed the checksum and, for a supported dump, the parameters
    if (pos >= int'(fmsx_pkg::HDR_LEN) && pos < data_end) begin
      d        = pos - int'(fmsx_pkg::HDR_LEN);
      data_sum = data_sum + b[6:0];
      if (params_on) begin
        if (msg_format == fmsx_pkg::FMT_SINGLE) begin
          push_param(5'd0, d, b);
          if (d == fmsx_pkg::LAST_SINGLE_D)
            push_param(5'd0, fmsx_pkg::FILL_PARAM, fmsx_pkg::FILL_VALUE);
        end else begin
          split_packed_byte(5'(d >> 7), d & 127, b);
        end
      end
    end else if (pos >= int'(fmsx_pkg::HDR_LEN) && pos == data_end) begin
      check_byte = b;
    end

    if (msg_pos != fmsx_pkg::POS_MAX) msg_pos = msg_pos + 15'd1;

    // the final byte closes the message with one status
    if (fin) begin
      total      = pos + 1;
      want_check = 7'd0 - data_sum;
      st         = '0;
      st.kind    = fmsx_pkg::KIND_STATUS;
      if (total < 8 || !sox_seen || b != fmsx_pkg::EOX_BYTE)
        st.status = fmsx_pkg::ST_FRAMING;
      else if (!maker_seen) st.status = fmsx_pkg::ST_MAKER;
      else if (total != int'(msg_len) + 8) st.status = fmsx_pkg::ST_COUNT;
      else if ({1'b0, want_check} != check_byte) st.status = fmsx_pkg::ST_CHECKSUM;
      else if (!dump_supported(msg_format, msg_len)) st.status = fmsx_pkg::ST_FORMAT;
      else st.status = fmsx_pkg::ST_OK;
      keep_result(st);
      clear_message();
    end

    if (byte_results.size() != 0) byte_results[byte_results.size() - 1].last_of_run = 1'b1;
    foreach (byte_results[i])
      predicted_results.insert(predicted_results.size(), byte_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Message builder
  // --------------------------------------------------------------------------
  logic [7:0] msg_bytes[$];
  logic [6:0] msg_sum;

  function automatic logic rand_bit();
    return 1'($urandom_range(1, 0));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic void add_byte(logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endfunction

  function automatic void start_msg(logic [7:0] sox, logic [7:0] maker, logic [7:0] fmt,
                                    logic [7:0] len_hi, logic [7:0] len_lo);
    msg_bytes.delete();
    msg_sum = '0;
    add_byte(sox);
    add_byte(maker);
    add_byte(rand_byte());
    add_byte(fmt);
    add_byte(len_hi);
    add_byte(len_lo);
  endfunction

  // wide: full 8-bit data bytes instead of MIDI 7-bit ones
  function automatic void add_data(int unsigned n, logic wide);
    logic [7:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      b = wide ? rand_byte() : 8'($urandom_range(127, 0));
      add_byte(b);
      msg_sum = msg_sum + b[6:0];
    end
  endfunction

  function automatic void add_check(logic good);
    logic [6:0] c;
    c = 7'd0 - msg_sum;
    add_byte(good ? {1'b0, c} : rand_byte());
  endfunction

  // Queue the built message, final flag on its last byte.
  function automatic void send_msg();
    fmsx_pkg::in_item_t it;
    foreach (msg_bytes[i]) begin
      it.in_byte  = msg_bytes[i];
      it.is_final = (i == msg_bytes.size() - 1);
      byte_feed.insert(byte_feed.size(), it);
    end
  endfunction

  // Short messages and noise, a few bytes each.
  function automatic void queue_random_message();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  sox;
    logic [7:0]  maker;
    logic [7:0]  fmt;
    pick = $urandom_range(3, 0);
    if (pick < 3) begin
      // short message sized right, header fields at random
      n     = $urandom_range(6, 0);
      sox   = ($urandom_range(3, 0) == 0) ? rand_byte() : fmsx_pkg::SOX_BYTE;
      maker = ($urandom_range(3, 0) == 0) ? rand_byte() : fmsx_pkg::MAKER_ID;
      case ($urandom_range(2, 0))
        0:       fmt = fmsx_pkg::FMT_SINGLE;
        1:       fmt = fmsx_pkg::FMT_BULK;
        default: fmt = rand_byte();
      endcase
      start_msg(sox, maker, fmt, {rand_bit(), 7'd0}, {rand_bit(), 7'(n)});
      add_data(n, 1'b1);
      add_check($urandom_range(3, 0) != 0);
      add_byte(($urandom_range(3, 0) != 0) ? fmsx_pkg::EOX_BYTE : rand_byte());
    end else begin
      // noise
      msg_bytes.delete();
      n = $urandom_range(10, 1);
      repeat (n) add_byte(rand_byte());
    end
    send_msg();
  endfunction

  // --------------------------------------------------------------------------
  // Driver: when the channel is free, offers the next byte unless it idles at
  // random; valid holds until the transfer happens.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (byte_feed.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item  <= byte_feed.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on each input transfer, checks each result transfer
  // against the oldest prediction.
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    fmsx_pkg::out_item_t want;
    if (!rst) begin
      if (in_valid && in_ready) predict_byte(in_item.in_byte, in_item.is_final);
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result: kind %0d voice %0d param %0d value %0d status %0d",
                 out_item.kind, out_item.voice, out_item.param, out_item.value,
                 out_item.status);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("kind", want.kind, out_item.kind);
          check_field("voice", want.voice, out_item.voice);
          check_field("param", want.param, out_item.param);
          check_field("value", want.value, out_item.value);
          check_field("status", want.status, out_item.status);
          check_field("last_of_run", want.last_of_run, out_item.last_of_run);
        end
      end
    end
  end

  // Hold off new bytes until everything sent has been transferred and every
  // predicted result has come out, then give the block time to settle.
  task automatic drain();
    while (byte_feed.size() != 0 || in_valid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    clear_message();

    // Phase 1: sender idles 35%, receiver 80%.
    send_idle_pct = 35;
    recv_idle_pct = 80;

    // lone final byte: too short
    msg_bytes = {fmsx_pkg::EOX_BYTE};
    send_msg();
    // wrong maker; size bytes with bit 7 set count only their low bits
    start_msg(fmsx_pkg::SOX_BYTE, 8'h41, fmsx_pkg::FMT_SINGLE, 8'h80, 8'h80);
    add_check(1'b1);
    add_byte(fmsx_pkg::EOX_BYTE);
    send_msg();
    // unknown format, otherwise clean
    start_msg(fmsx_pkg::SOX_BYTE, fmsx_pkg::MAKER_ID, 8'hFF, 8'h80, 8'h80);
    add_check(1'b1);
    add_byte(fmsx_pkg::EOX_BYTE);
    send_msg();
    // final flag on a data byte of a single dump: params, then status
    start_msg(fmsx_pkg::SOX_BYTE, fmsx_pkg::MAKER_ID, fmsx_pkg::FMT_SINGLE,
              {1'b0, fmsx_pkg::LEN_SINGLE[13:7]}, {1'b0, fmsx_pkg::LEN_SINGLE[6:0]});
    add_data(2, 1'b1);
    send_msg();

    while (byte_feed.size() < 60) queue_random_message();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    drain();

    // Phase 2: sender idles 80%, receiver 35%. A bulk dump covers every packed
    // offset of voice 0 and stops on a data byte of voice 1.
    send_idle_pct = 80;
    recv_idle_pct = 35;
    start_msg(fmsx_pkg::SOX_BYTE, fmsx_pkg::MAKER_ID, fmsx_pkg::FMT_BULK,
              {1'b0, fmsx_pkg::LEN_BULK[13:7]}, {1'b0, fmsx_pkg::LEN_BULK[6:0]});
    add_data(130, 1'b1);
    send_msg();
    drain();

    // Phase 3: no idling.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (byte_feed.size() < 30) queue_random_message();
    drain();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
